[rtl/core/nabc_pkg.sv]
// Shared types and constants of the neighbour absolute difference band classifier.
package nabc_pkg;

    // Width of the difference and mean results; the band registers are BAND_BITS wide.
    localparam int OUT_BITS      = 16;
    localparam int BAND_BITS     = 17;
    localparam int CNT_BITS      = 4;
    localparam int COUNT_BITS    = 2;
    localparam int LANES         = 8;
    localparam int MEAN_SHIFT    = 3;
    localparam int APB_DATA_BITS = 32;

    // Register map, in units of one 32-bit register.
    localparam int REG_BAND_COUNT = 0;
    localparam int REG_SKIP_BLACK = 1;
    localparam int REG_BAND_BASE  = 2;
    localparam int BAND_FIELDS    = 3;

    // Field offsets inside one band's group of registers.
    localparam int FLD_LOW   = 0;
    localparam int FLD_HIGH  = 1;
    localparam int FLD_COLOR = 2;

    // A colour of -1 keeps the tested value.
    localparam logic [BAND_BITS-1:0] COLOR_KEEP  = '1;
    localparam logic [BAND_BITS-1:0] HIGH_RESET  = 17'h10000;

    typedef struct packed {
        logic [BAND_BITS-1:0] low;
        logic [BAND_BITS-1:0] high;
        logic [BAND_BITS-1:0] color;
    } t_band;

    // Load strobes for the two merge stages.
    typedef struct packed {
        logic load_sum;
        logic load_out;
    } t_pipe_ctrl;

endpackage

[rtl/core/neighbour_absdiff_band_classify.sv]
// Top level of the 3x3 neighbourhood absolute difference and band classifier.
// One input word carries a centre pixel and its eight neighbours; one output word
// carries the eight classified absolute differences, their classified mean and the
// number of differences that were counted. The block takes one word per clock while
// the output is not stalled and has three register stages. The edge that accepts a
// word loads the first stage, the lane registers; from there the word moves on to the
// second stage and then to the output register. Eight parallel lanes form and classify
// the differences in the first stage, two four-input sums and the hit count are
// registered in the second, and the full sum with the mean's band test lands in the
// output register in the third. Every stage holds its own valid bit and refills
// as soon as the next stage takes its word, so a result waiting at the output does
// not stop the input until all three stages are full. With no bands active the raw
// differences pass and the mean is the sum over eight rounded half up; with bands
// active each value takes the colour of the last band that holds it, keeps itself
// when that colour is -1, and becomes zero when no band holds it. Band counts above
// NUM_BANDS act as NUM_BANDS. Registers sit on the APB port at byte address 4*i:
// band_count, skip_black, then low, high and colour of each band in turn. They are
// meant to be written while no word is in flight.
module neighbour_absdiff_band_classify import nabc_pkg::*; #(
    parameter int PIXEL_BITS = 16,
    parameter int NUM_BANDS  = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [$clog2(2+3*NUM_BANDS)+1:0]    paddr,
    input  logic [APB_DATA_BITS-1:0]            pwdata,
    output logic [APB_DATA_BITS-1:0]            prdata,
    output logic                                pready,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0 up: centre_pixel, nbr_left_up, nbr_left_mid, nbr_left_down,
    // nbr_mid_up, nbr_mid_down, nbr_right_up, nbr_right_mid, nbr_right_down.
    input  logic [((9*PIXEL_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // Output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0 up: diff_0 .. diff_7, mean_out, hit_count.
    output logic [((9*OUT_BITS+CNT_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int NUM_REGS  = REG_BAND_BASE + BAND_FIELDS * NUM_BANDS;
    localparam int IDX_BITS  = $clog2(NUM_REGS);
    localparam int ADDR_BITS = IDX_BITS + 2;
    localparam int OUT_TDATA = ((9*OUT_BITS+CNT_BITS+7)/8)*8;

    // Configuration registers.
    logic [COUNT_BITS-1:0] r_band_count;
    logic                  r_skip_black;
    t_band                 r_bands [NUM_BANDS];

    logic [IDX_BITS-1:0]   reg_idx;
    logic                  cfg_write;

    // Pipeline valid bits and load strobes.
    logic       r_v1, r_v2, r_v3;
    logic       load1, load2, load3;
    t_pipe_ctrl ctrl;

    logic [PIXEL_BITS-1:0] centre;
    logic [PIXEL_BITS-1:0] nbr      [LANES];
    logic [PIXEL_BITS-1:0] lane_raw [LANES];
    logic [OUT_BITS-1:0]   lane_val [LANES];
    logic                  lane_cnt [LANES];
    logic [OUT_BITS-1:0]   res_diff [LANES];
    logic [OUT_BITS-1:0]   res_mean;
    logic [CNT_BITS-1:0]   res_hits;

    // ------------------------------------------------------------------
    // APB register file. A write lands at the access phase.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_count <= '0;
            r_skip_black <= 1'b0;
            for (int b = 0; b < NUM_BANDS; b++) begin
                r_bands[b].low   <= '0;
                r_bands[b].high  <= HIGH_RESET;
                r_bands[b].color <= COLOR_KEEP;
            end
        end else if (cfg_write) begin
            if (reg_idx == IDX_BITS'(REG_BAND_COUNT)) begin
                r_band_count <= pwdata[COUNT_BITS-1:0];
            end
            if (reg_idx == IDX_BITS'(REG_SKIP_BLACK)) begin
                r_skip_black <= pwdata[0];
            end
            for (int b = 0; b < NUM_BANDS; b++) begin
                if (reg_idx == IDX_BITS'(REG_BAND_BASE + BAND_FIELDS*b + FLD_LOW)) begin
                    r_bands[b].low <= pwdata[BAND_BITS-1:0];
                end
                if (reg_idx == IDX_BITS'(REG_BAND_BASE + BAND_FIELDS*b + FLD_HIGH)) begin
                    r_bands[b].high <= pwdata[BAND_BITS-1:0];
                end
                if (reg_idx == IDX_BITS'(REG_BAND_BASE + BAND_FIELDS*b + FLD_COLOR)) begin
                    r_bands[b].color <= pwdata[BAND_BITS-1:0];
                end
            end
        end
    end

    // Read back; the colour comes back sign extended.
    always_comb begin
        prdata = '0;
        if (reg_idx == IDX_BITS'(REG_BAND_COUNT)) begin
            prdata = APB_DATA_BITS'(r_band_count);
        end
        if (reg_idx == IDX_BITS'(REG_SKIP_BLACK)) begin
            prdata = APB_DATA_BITS'(r_skip_black);
        end
        for (int b = 0; b < NUM_BANDS; b++) begin
            if (reg_idx == IDX_BITS'(REG_BAND_BASE + BAND_FIELDS*b + FLD_LOW)) begin
                prdata = APB_DATA_BITS'(r_bands[b].low);
            end
            if (reg_idx == IDX_BITS'(REG_BAND_BASE + BAND_FIELDS*b + FLD_HIGH)) begin
                prdata = APB_DATA_BITS'(r_bands[b].high);
            end
            if (reg_idx == IDX_BITS'(REG_BAND_BASE + BAND_FIELDS*b + FLD_COLOR)) begin
                prdata = {{(APB_DATA_BITS-BAND_BITS){r_bands[b].color[BAND_BITS-1]}},
                          r_bands[b].color};
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. Each stage loads when it is empty or when the
    // stage after it takes its word in the same cycle.
    // ------------------------------------------------------------------
    assign load3         = r_v2 && (!r_v3 || m_axis_tready);
    assign load2         = r_v1 && (!r_v2 || load3);
    assign s_axis_tready = !r_v1 || load2;
    assign load1         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_v3;

    assign ctrl.load_sum = load2;
    assign ctrl.load_out = load3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (load1) begin
                r_v1 <= 1'b1;
            end else if (load2) begin
                r_v1 <= 1'b0;
            end
            if (load2) begin
                r_v2 <= 1'b1;
            end else if (load3) begin
                r_v2 <= 1'b0;
            end
            if (load3) begin
                r_v3 <= 1'b1;
            end else if (m_axis_tready) begin
                r_v3 <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Eight difference lanes side by side.
    // ------------------------------------------------------------------
    assign centre = s_axis_tdata[PIXEL_BITS-1:0];

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        assign nbr[k] = s_axis_tdata[(k+1)*PIXEL_BITS +: PIXEL_BITS];

        nabc_lane #(
            .PIXEL_BITS (PIXEL_BITS),
            .NUM_BANDS  (NUM_BANDS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_load       (load1),
            .i_centre     (centre),
            .i_nbr        (nbr[k]),
            .i_bands      (r_bands),
            .i_band_count (r_band_count),
            .i_skip_black (r_skip_black),
            .o_raw        (lane_raw[k]),
            .o_value      (lane_val[k]),
            .o_count      (lane_cnt[k])
        );
    end

    nabc_merge #(
        .PIXEL_BITS (PIXEL_BITS),
        .NUM_BANDS  (NUM_BANDS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_ctrl       (ctrl),
        .i_raw        (lane_raw),
        .i_value      (lane_val),
        .i_count      (lane_cnt),
        .i_bands      (r_bands),
        .i_band_count (r_band_count),
        .o_diff       (res_diff),
        .o_mean       (res_mean),
        .o_hits       (res_hits)
    );

    // Pack the result word, diff_0 in the lowest bits.
    always_comb begin
        m_axis_tdata = '0;
        for (int k = 0; k < LANES; k++) begin
            m_axis_tdata[k*OUT_BITS +: OUT_BITS] = res_diff[k];
        end
        m_axis_tdata[LANES*OUT_BITS +: OUT_BITS]           = res_mean;
        m_axis_tdata[(LANES+1)*OUT_BITS +: CNT_BITS]       = res_hits;
        m_axis_tdata[OUT_TDATA-1:(LANES+1)*OUT_BITS+CNT_BITS] = '0;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The input only stalls when every stage holds a word.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled while a pipeline stage was empty");

    // An accepted word always occupies the lane stage on the next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load1 |=> r_v1)
        else $error("accepted word lost before the lane stage");

    // No more differences can be counted than there are lanes.
    a_hits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res_hits <= CNT_BITS'(LANES)))
        else $error("hit count exceeds the number of lanes");

endmodule

[rtl/core/nabc_classify.sv]
// Band test of one value against all active bands; the last matching band wins.
module nabc_classify import nabc_pkg::*; #(
    parameter int VAL_BITS  = 16,
    parameter int SHIFT     = 0,
    parameter int NUM_BANDS = 2
) (
    input  logic [VAL_BITS-1:0]   i_value,
    input  t_band                 i_bands [NUM_BANDS],
    input  logic [COUNT_BITS-1:0] i_band_count,
    output logic [OUT_BITS-1:0]   o_value,
    output logic                  o_hit
);

    localparam int CW = (VAL_BITS > BAND_BITS + SHIFT) ? VAL_BITS : BAND_BITS + SHIFT;

    always_comb begin
        logic [CW-1:0] val_ext;
        logic [CW-1:0] kept;
        logic          match;
        val_ext = CW'(i_value);
        kept    = val_ext >> SHIFT;
        o_value = '0;
        o_hit   = 1'b0;
        for (int b = 0; b < NUM_BANDS; b++) begin
            // Bounds are scaled like the value, so the mean is tested exactly.
            match = (32'(b) < 32'(i_band_count))
                 && (val_ext >= (CW'(i_bands[b].low) << SHIFT))
                 && (val_ext <  (CW'(i_bands[b].high) << SHIFT));
            if (match) begin
                o_hit   = 1'b1;
                o_value = (i_bands[b].color == COLOR_KEEP) ? kept[OUT_BITS-1:0]
                                                           : i_bands[b].color[OUT_BITS-1:0];
            end
        end
    end

endmodule

[rtl/core/nabc_lane.sv]
// One difference lane: absolute difference, black skipping and band test, registered.
module nabc_lane import nabc_pkg::*; #(
    parameter int PIXEL_BITS = 16,
    parameter int NUM_BANDS  = 2
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [PIXEL_BITS-1:0] i_centre,
    input  logic [PIXEL_BITS-1:0] i_nbr,
    input  t_band                 i_bands [NUM_BANDS],
    input  logic [COUNT_BITS-1:0] i_band_count,
    input  logic                  i_skip_black,
    output logic [PIXEL_BITS-1:0] o_raw,
    output logic [OUT_BITS-1:0]   o_value,
    output logic                  o_count
);

    localparam int DW = (PIXEL_BITS > OUT_BITS) ? PIXEL_BITS : OUT_BITS;

    logic                  skip;
    logic [PIXEL_BITS-1:0] diff;
    logic [DW-1:0]         diff_ext;
    logic [OUT_BITS-1:0]   cls_value;
    logic                  cls_hit;

    logic [PIXEL_BITS-1:0] r_raw,   n_raw;
    logic [OUT_BITS-1:0]   r_value, n_value;
    logic                  r_count, n_count;

    always_comb begin
        skip = i_skip_black && ((i_nbr == '0) || (i_centre == '0));
        if (skip) begin
            diff = '0;
        end else if (i_centre >= i_nbr) begin
            diff = i_centre - i_nbr;
        end else begin
            diff = i_nbr - i_centre;
        end
        diff_ext = DW'(diff);
    end

    nabc_classify #(
        .VAL_BITS  (PIXEL_BITS),
        .SHIFT     (0),
        .NUM_BANDS (NUM_BANDS)
    ) u_classify (
        .i_value      (diff),
        .i_bands      (i_bands),
        .i_band_count (i_band_count),
        .o_value      (cls_value),
        .o_hit        (cls_hit)
    );

    always_comb begin
        n_raw = diff;
        if (skip) begin
            n_value = '0;
        end else if (i_band_count == '0) begin
            n_value = diff_ext[OUT_BITS-1:0];
        end else begin
            n_value = cls_value;
        end
        n_count = !skip && ((i_band_count == '0) || cls_hit);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_raw   <= n_raw;
            r_value <= n_value;
            r_count <= n_count;
        end
    end

    assign o_raw   = r_raw;
    assign o_value = r_value;
    assign o_count = r_count;

endmodule

[rtl/core/nabc_merge.sv]
// Merge stages: half sums and hit count, then total, mean band test and result register.
module nabc_merge import nabc_pkg::*; #(
    parameter int PIXEL_BITS = 16,
    parameter int NUM_BANDS  = 2
) (
    input  logic                  i_clk,
    input  t_pipe_ctrl            i_ctrl,
    input  logic [PIXEL_BITS-1:0] i_raw   [LANES],
    input  logic [OUT_BITS-1:0]   i_value [LANES],
    input  logic                  i_count [LANES],
    input  t_band                 i_bands [NUM_BANDS],
    input  logic [COUNT_BITS-1:0] i_band_count,
    output logic [OUT_BITS-1:0]   o_diff  [LANES],
    output logic [OUT_BITS-1:0]   o_mean,
    output logic [CNT_BITS-1:0]   o_hits
);

    localparam int HALF      = LANES / 2;
    localparam int HALF_BITS = PIXEL_BITS + $clog2(HALF);
    localparam int SUM_BITS  = PIXEL_BITS + MEAN_SHIFT;
    localparam int RW        = (SUM_BITS + 1 > OUT_BITS + MEAN_SHIFT)
                             ? SUM_BITS + 1 : OUT_BITS + MEAN_SHIFT;
    localparam int ROUND     = 1 << (MEAN_SHIFT - 1);

    logic [HALF_BITS-1:0] r_half [2];
    logic [HALF_BITS-1:0] n_half [2];
    logic [CNT_BITS-1:0]  r_hits2, n_hits2;
    logic [OUT_BITS-1:0]  r_value2 [LANES];

    logic [SUM_BITS-1:0]  total;
    logic [RW-1:0]        rounded;
    logic [OUT_BITS-1:0]  cls_mean;
    logic                 cls_hit;
    logic [OUT_BITS-1:0]  n_mean;

    logic [OUT_BITS-1:0]  r_diff [LANES];
    logic [OUT_BITS-1:0]  r_mean;
    logic [CNT_BITS-1:0]  r_hits;

    // Stage two: two sums of four lanes each, plus the count of counted lanes.
    always_comb begin
        n_half[0] = '0;
        n_half[1] = '0;
        n_hits2   = '0;
        for (int k = 0; k < HALF; k++) begin
            n_half[0] = n_half[0] + HALF_BITS'(i_raw[k]);
            n_half[1] = n_half[1] + HALF_BITS'(i_raw[k + HALF]);
        end
        for (int k = 0; k < LANES; k++) begin
            n_hits2 = n_hits2 + CNT_BITS'(i_count[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_sum) begin
            r_half  <= n_half;
            r_hits2 <= n_hits2;
            r_value2 <= i_value;
        end
    end

    // Stage three: full sum, then either rounded mean or band test of the exact mean.
    always_comb begin
        total   = SUM_BITS'(r_half[0]) + SUM_BITS'(r_half[1]);
        rounded = RW'(total) + RW'(ROUND);
    end

    nabc_classify #(
        .VAL_BITS  (SUM_BITS),
        .SHIFT     (MEAN_SHIFT),
        .NUM_BANDS (NUM_BANDS)
    ) u_classify_mean (
        .i_value      (total),
        .i_bands      (i_bands),
        .i_band_count (i_band_count),
        .o_value      (cls_mean),
        .o_hit        (cls_hit)
    );

    always_comb begin
        if (i_band_count == '0) begin
            n_mean = rounded[OUT_BITS+MEAN_SHIFT-1:MEAN_SHIFT];
        end else begin
            // A mean outside every band reads as zero; it never adds to the count.
            n_mean = cls_hit ? cls_mean : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            r_diff <= r_value2;
            r_mean <= n_mean;
            r_hits <= r_hits2;
        end
    end

    assign o_diff = r_diff;
    assign o_mean = r_mean;
    assign o_hits = r_hits;

endmodule
